@@ hw/rtl/nsc_pkg.sv @@
// Package of constants and types for the subset construction block.
`timescale 1ns / 1ps
package nsc_pkg;
  localparam int MAX_NFA_STATES = 16;
  localparam int MAX_SYMBOLS    = 8;
  localparam int MAX_DFA_NODES  = 256;
  localparam int SW = $clog2(MAX_NFA_STATES);
  localparam int YW = $clog2(MAX_SYMBOLS);
  localparam int NW = $clog2(MAX_DFA_NODES);

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_EDGE   = 2'd1;
  localparam logic [1:0] OP_FINAL  = 2'd2;
  localparam logic [1:0] OP_EXPAND = 2'd3;

  localparam logic [1:0] KIND_EDGE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_OVF   = 2'd3;

  localparam logic [1:0] REG_NSTATES = 2'd0;
  localparam logic [1:0] REG_NSYM    = 2'd1;
  localparam logic [1:0] REG_START   = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] from_state;
    logic [2:0] symbol;
    logic [3:0] to_state;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  source_node;
    logic        source_is_final;
    logic [2:0]  edge_symbol;
    logic [7:0]  target_node;
    logic [15:0] target_subset;
    logic        target_is_final;
    logic        target_is_new;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] index;
    logic [4:0] data;
  } cfg_word_t;
endpackage

@@ hw/rtl/nsc_if.sv @@
// Valid/ready channel interfaces for the subset construction block.
`timescale 1ns / 1ps
interface nsc_in_if import nsc_pkg::*;;
  logic valid, ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsc_out_if import nsc_pkg::*;;
  logic valid, ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nsc_cfg_if import nsc_pkg::*;;
  logic valid, ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/nfa_subset_construction.sv @@
// Top level of the NFA to DFA subset construction sequencer.
`timescale 1ns / 1ps
// Words are taken one at a time, and in_ch.ready stays low until the previous word has
// been dealt with. After reset, and after every op 0, a pass clears all 128 entries of
// the successor memory, and op 0 holds the block until that pass ends. Op 1 is a
// read-modify-write through S_EDGEW; op 2 is done in the cycle it is taken.
// Op 3 with nothing pending offers its word in the next cycle. Otherwise S_POPW and
// S_POP pop the node, then for each symbol S_ACC and S_ACCW read the successors of
// each state in use; a non-empty target adds a search of the subset table through
// S_SCAN and S_SCANW, then S_EMIT hands over the held edge word, with any stall on
// out_ch, and registers the new one. Each edge word is held back until the next
// outcome is known, so that the last one can carry last; the final word waits in S_END
// until taken. Configuration writes belong only between words.
module nfa_subset_construction import nsc_pkg::*; (
  input logic clk,
  input logic rst,
  nsc_in_if.sink   in_ch,
  nsc_out_if.source out_ch,
  nsc_cfg_if.sink  cfg
);
  localparam int MD = MAX_NFA_STATES * MAX_SYMBOLS;
  localparam int MAW = $clog2(MD);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_POP = 4'd2, S_ACC = 4'd3,
    S_ACCW = 4'd4, S_SYMEND = 4'd5, S_SCAN = 4'd6, S_SCANW = 4'd7, S_EMIT = 4'd8,
    S_END = 4'd9, S_POPW = 4'd10, S_EDGEW = 4'd11;

  logic [3:0] state;
  logic [4:0] nfa_state_count;
  logic [3:0] alphabet_size, start_state;

  logic [15:0] succ_mem [MD];
  logic [15:0] subset_mem [MAX_DFA_NODES];
  logic [15+NW:0] stack_mem [MAX_DFA_NODES];
  logic [MAW-1:0] sa;
  logic [15:0] succ_rd, subset_rd;
  logic [15+NW:0] stack_rd;
  logic succ_we; logic [15:0] succ_wd;
  logic [MAW-1:0] succ_wa;

  logic [15:0] final_mask, act, cur, tgt;
  logic [NW:0] node_count, stack_pointer, idx;
  logic [NW-1:0] src_node;
  logic cur_fin, emitted, found, ovf;
  logic [SW:0] v, nst;
  logic [YW:0] a, nsy;
  logic [MAW:0] clr_cnt;
  in_word_t w;
  out_word_t ow;
  logic ovalid;

  function automatic out_word_t make_word(logic [1:0] kind, logic [7:0] src, logic sfin,
                                          logic [2:0] sym, logic [7:0] tnode,
                                          logic [15:0] tsub, logic tfin, logic tnew,
                                          logic is_last);
    out_word_t r;
    r.kind = kind;
    r.source_node = src;
    r.source_is_final = sfin;
    r.edge_symbol = sym;
    r.target_node = tnode;
    r.target_subset = tsub;
    r.target_is_final = tfin;
    r.target_is_new = tnew;
    r.last = is_last;
    return r;
  endfunction

  assign nst = (nfa_state_count > 5'(MAX_NFA_STATES)) ? (SW+1)'(MAX_NFA_STATES)
               : (SW+1)'(nfa_state_count);
  assign nsy = (alphabet_size > 4'(MAX_SYMBOLS)) ? (YW+1)'(MAX_SYMBOLS)
               : (YW+1)'(alphabet_size);
  always_comb begin
    for (int k = 0; k < 16; k++) act[k] = (k < int'(nst));
  end

  assign in_ch.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_ch.valid = ovalid;
  assign out_ch.data = ow;

  always_ff @(posedge clk) begin
    if (succ_we) succ_mem[succ_wa] <= succ_wd;
    succ_rd <= succ_mem[sa];
    subset_rd <= subset_mem[idx[NW-1:0]];
    stack_rd <= stack_mem[stack_pointer[NW-1:0]];
  end

  always_comb begin
    succ_we = 1'b0; succ_wa = sa; succ_wd = succ_rd;
    if (state == S_CLR) begin
      succ_we = 1'b1; succ_wa = clr_cnt[MAW-1:0]; succ_wd = '0;
    end else if (state == S_EDGEW) begin
      succ_we = 1'b1; succ_wd = succ_rd | (16'd1 << w.to_state);
    end
  end

  always_comb begin
    sa = '0;
    if (state == S_IDLE || state == S_EDGEW)
      sa = MAW'({w.from_state, w.symbol});
    else
      sa = MAW'({v[SW-1:0], a[YW-1:0]});
    if (state == S_IDLE && in_ch.valid)
      sa = MAW'({in_ch.data.from_state, in_ch.data.symbol});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; clr_cnt <= '0; ovalid <= 1'b0;
      nfa_state_count <= 5'd16; alphabet_size <= 4'd8; start_state <= '0;
      final_mask <= '0; node_count <= '0; stack_pointer <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_NSTATES: nfa_state_count <= cfg.data.data;
          REG_NSYM:    alphabet_size <= cfg.data.data[3:0];
          REG_START:   start_state <= cfg.data.data[3:0];
          default: ;
        endcase
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (MAW+1)'(MD-1)) state <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid) begin
          w <= in_ch.data;
          unique case (in_ch.data.op)
            OP_CLEAR: begin
              final_mask <= '0; clr_cnt <= '0; state <= S_CLR;
              subset_mem[0] <= 16'd1 << start_state;
              stack_mem[0] <= {16'd1 << start_state, NW'(0)};
              node_count <= (NW+1)'(1); stack_pointer <= (NW+1)'(1);
            end
            OP_EDGE: state <= S_EDGEW;
            OP_FINAL: final_mask <= final_mask | (16'd1 << in_ch.data.from_state);
            OP_EXPAND: begin
              if (stack_pointer == '0) begin
                ow <= make_word(KIND_NONE, 8'd0, 1'b0, 3'd0, 8'd0, 16'd0, 1'b0, 1'b0, 1'b1);
                ovalid <= 1'b1; state <= S_END;
              end else begin
                stack_pointer <= stack_pointer - 1'b1; state <= S_POPW;
              end
            end
            default: ;
          endcase
        end
        S_EDGEW: state <= S_IDLE;
        S_POPW: state <= S_POP;
        S_POP: begin
          cur <= stack_rd[15+NW:NW]; src_node <= stack_rd[NW-1:0];
          cur_fin <= |(stack_rd[15+NW:NW] & final_mask & act);
          emitted <= 1'b0; a <= '0; v <= '0; tgt <= '0;
          state <= (nsy == '0) ? S_SYMEND : S_ACC;
        end
        S_ACC: begin
          // walk member states one at a time; read data lands next cycle
          if (v == nst) begin
            state <= S_SYMEND;
          end else state <= S_ACCW;
        end
        S_ACCW: begin
          if (cur[v[SW-1:0]]) tgt <= tgt | succ_rd;
          v <= v + 1'b1; state <= S_ACC;
        end
        S_SYMEND: begin
          if (a == nsy) begin
            if (!emitted) begin
              ow <= make_word(KIND_EMPTY, src_node, cur_fin, 3'd0, 8'd0, 16'd0,
                              1'b0, 1'b0, 1'b1);
              ovalid <= 1'b1; state <= S_END;
            end else begin
              ow.last <= 1'b1; ovalid <= 1'b1; state <= S_END;
            end
          end else if ((tgt & act) == '0) begin
            a <= a + 1'b1; v <= '0; tgt <= '0;
            state <= (a + 1'b1 == nsy) ? S_SYMEND : S_ACC;
          end else begin
            tgt <= tgt & act; idx <= '0; found <= 1'b0; state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx == node_count) begin
            ovf <= (node_count >= (NW+1)'(MAX_DFA_NODES)) ||
                   (stack_pointer >= (NW+1)'(MAX_DFA_NODES));
            state <= S_EMIT;
          end else state <= S_SCANW;
        end
        S_SCANW: begin
          if (subset_rd == tgt) begin found <= 1'b1; state <= S_EMIT; end
          else begin idx <= idx + 1'b1; state <= S_SCAN; end
        end
        S_EMIT: begin
          // The edge word held from an earlier symbol goes out first, as this
          // outcome shows that it was not the last.
          if (ovalid) begin
            if (out_ch.ready) begin
              ovalid <= 1'b0; emitted <= 1'b0;
            end
          end else if (emitted) begin
            ovalid <= 1'b1;
          end else if (!found && ovf) begin
            ow <= make_word(KIND_OVF, src_node, cur_fin, a[YW-1:0], 8'd0, tgt,
                            1'b0, 1'b0, 1'b1);
            ovalid <= 1'b1; state <= S_END;
          end else begin
            ow <= make_word(KIND_EDGE, src_node, cur_fin, a[YW-1:0],
                            found ? idx[7:0] : node_count[7:0], tgt,
                            |(tgt & final_mask), !found, 1'b0);
            if (!found) begin
              subset_mem[node_count[NW-1:0]] <= tgt;
              stack_mem[stack_pointer[NW-1:0]] <= {tgt, node_count[NW-1:0]};
              node_count <= node_count + 1'b1;
              stack_pointer <= stack_pointer + 1'b1;
            end
            emitted <= 1'b1;
            a <= a + 1'b1; v <= '0; tgt <= '0;
            state <= (a + 1'b1 == nsy) ? S_SYMEND : S_ACC;
          end
        end
        S_END: if (ovalid && out_ch.ready) begin
          ovalid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the NFA to DFA subset construction block.
`timescale 1ns / 1ps
module testbench;
  import nsc_pkg::*;

  localparam int SETTLE_CYCLES = 400;

  class dfa_scoreboard;
    logic [4:0]  nstates_reg;
    logic [3:0]  nsym_reg;
    logic [3:0]  start_reg;
    logic [15:0] succ_mask [MAX_NFA_STATES*MAX_SYMBOLS];
    logic [15:0] final_states;
    logic [15:0] subset_of_node [MAX_DFA_NODES];
    int          node_total;
    logic [15:0] pending_subset [MAX_DFA_NODES];
    int          pending_node [MAX_DFA_NODES];
    int          pending_depth;
    out_word_t   expected_words [$];
    int          errors;
    int          overflows;

    function new();
      nstates_reg = 5'd16;
      nsym_reg = 4'd8;
      start_reg = 4'd0;
      errors = 0;
      overflows = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (succ_mask[i]) succ_mask[i] = '0;
      final_states = '0;
      node_total = 0;
      pending_depth = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [4:0] value);
      case (idx)
        REG_NSTATES: nstates_reg = value;
        REG_NSYM:    nsym_reg = value[3:0];
        REG_START:   start_reg = value[3:0];
        default: ;
      endcase
    endfunction

    function out_word_t blank(logic [1:0] kind);
      out_word_t w;
      w = '0;
      w.kind = kind;
      return w;
    endfunction

    function void note_input(in_word_t w);
      out_word_t res [$];
      out_word_t r;
      logic [15:0] act, cur, tgt;
      logic cur_fin;
      int n, nsym, src_node, tnode;
      bit found, stop;
      case (w.op)
        OP_CLEAR: begin
          wipe();
          subset_of_node[0] = 16'd1 << start_reg;
          pending_subset[0] = subset_of_node[0];
          pending_node[0] = 0;
          node_total = 1;
          pending_depth = 1;
        end
        OP_EDGE: succ_mask[w.from_state*MAX_SYMBOLS + w.symbol] |= 16'd1 << w.to_state;
        OP_FINAL: final_states |= 16'd1 << w.from_state;
        default: begin
          if (pending_depth == 0) begin
            r = blank(KIND_NONE);
            res.push_back(r);
          end else begin
            pending_depth--;
            n = (nstates_reg > MAX_NFA_STATES) ? MAX_NFA_STATES : nstates_reg;
            nsym = (nsym_reg > MAX_SYMBOLS) ? MAX_SYMBOLS : nsym_reg;
            act = (n >= 16) ? 16'hFFFF : ((16'd1 << n) - 16'd1);
            cur = pending_subset[pending_depth];
            src_node = pending_node[pending_depth];
            cur_fin = |(cur & final_states & act);
            stop = 0;
            for (int a = 0; a < nsym && !stop; a++) begin
              tgt = '0;
              for (int v = 0; v < n; v++)
                if (cur[v]) tgt |= succ_mask[v*MAX_SYMBOLS + a];
              tgt &= act;
              if (tgt != 0) begin
                found = 0;
                tnode = 0;
                for (int i = 0; i < node_total && !found; i++)
                  if (subset_of_node[i] == tgt) begin
                    found = 1;
                    tnode = i;
                  end
                r = blank(KIND_EDGE);
                r.source_node = 8'(src_node);
                r.source_is_final = cur_fin;
                r.edge_symbol = 3'(a);
                r.target_subset = tgt;
                if (!found && (node_total >= MAX_DFA_NODES || pending_depth >= MAX_DFA_NODES)) begin
                  r.kind = KIND_OVF;
                  overflows++;
                  stop = 1;
                end else begin
                  if (!found) begin
                    tnode = node_total;
                    subset_of_node[tnode] = tgt;
                    node_total++;
                    pending_subset[pending_depth] = tgt;
                    pending_node[pending_depth] = tnode;
                    pending_depth++;
                    r.target_is_new = 1;
                  end
                  r.target_node = 8'(tnode);
                  r.target_is_final = |(tgt & final_states);
                end
                res.push_back(r);
              end
            end
            if (res.size() == 0) begin
              r = blank(KIND_EMPTY);
              r.source_node = 8'(src_node);
              r.source_is_final = cur_fin;
              res.push_back(r);
            end
          end
          res[res.size()-1].last = 1;
          foreach (res[i]) expected_words.push_back(res[i]);
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare(string field, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        want = expected_words.pop_front();
        compare("kind", got.kind, want.kind);
        compare("source_node", got.source_node, want.source_node);
        compare("source_is_final", got.source_is_final, want.source_is_final);
        compare("edge_symbol", got.edge_symbol, want.edge_symbol);
        compare("target_node", got.target_node, want.target_node);
        compare("target_subset", got.target_subset, want.target_subset);
        compare("target_is_final", got.target_is_final, want.target_is_final);
        compare("target_is_new", got.target_is_new, want.target_is_new);
        compare("last", got.last, want.last);
      end
    endtask
  endclass

  logic clk;
  logic rst;
  bit   idling;
  int   out_stall;
  dfa_scoreboard sb;

  nsc_in_if  in_ch ();
  nsc_out_if out_ch ();
  nsc_cfg_if cfg ();

  nfa_subset_construction DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg(cfg.sink)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  function automatic int draw_gap();
    return idling ? $urandom_range(0, 12) : 0;
  endfunction

  // The receiver draws a fresh stall after every word it takes.
  always @(posedge clk) begin : receiver
    int stall;
    if (rst) begin
      out_stall <= 0;
      out_ch.ready <= 1'b1;
    end else if (out_ch.valid && out_ch.ready) begin
      sb.check(out_ch.data);
      stall = draw_gap();
      out_stall <= stall;
      out_ch.ready <= (stall == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ch.ready <= (out_stall == 1);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task send(logic [1:0] op, logic [3:0] from_s, logic [2:0] sym, logic [3:0] to_s);
    in_word_t w;
    int gap;
    w.op = op;
    w.from_state = from_s;
    w.symbol = sym;
    w.to_state = to_s;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(w);
  endtask

  // Sends an op with random other fields.
  task send_any(logic [1:0] op);
    send(op, 4'($urandom), 3'($urandom), 4'($urandom));
  endtask

  // Lets the block go quiet before a register write.
  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [4:0] value);
    cfg.valid <= 1'b1;
    cfg.data <= '{index: idx, data: value};
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  task set_all(logic [4:0] ns, logic [3:0] na, logic [3:0] st);
    write_reg(REG_NSTATES, ns);
    write_reg(REG_NSYM, {1'b0, na});
    write_reg(REG_START, {1'b0, st});
    cfg.valid <= 1'b0;
  endtask

  task expand_until_done(int cap);
    int k;
    k = 0;
    while (sb.pending_depth != 0 && k < cap) begin
      send_any(OP_EXPAND);
      k++;
    end
    send_any(OP_EXPAND);
  endtask

  initial begin
    int items, n_edges, ns;
    sb = new();
    idling = 1;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Nothing pending before any clear.
    send(OP_EXPAND, 4'd0, 3'd0, 4'd0);
    drain();
    set_all(5'd16, 4'd8, 4'd15);
    send(OP_CLEAR, 4'd0, 3'd0, 4'd0);
    send(OP_EDGE, 4'd15, 3'd7, 4'd0);
    send(OP_EDGE, 4'd15, 3'd0, 4'd15);
    send(OP_EDGE, 4'd0, 3'd3, 4'd0);
    send(OP_EDGE, 4'd0, 3'd3, 4'd15);
    send(OP_FINAL, 4'd15, 3'd0, 4'd0);
    send(OP_FINAL, 4'd0, 3'd0, 4'd0);
    expand_until_done(6);
    drain();
    // Start state outside the states in use: node 0 has no successors.
    set_all(5'd4, 4'd0, 4'd15);
    send(OP_CLEAR, 4'd0, 3'd0, 4'd0);
    send(OP_EDGE, 4'd15, 3'd0, 4'd1);
    send(OP_EXPAND, 4'd0, 3'd0, 4'd0);
    send(OP_EXPAND, 4'd0, 3'd0, 4'd0);
    drain();
    set_all(5'd31, 4'd15, 4'd0);
    send(OP_CLEAR, 4'd0, 3'd0, 4'd0);
    send(OP_EDGE, 4'd0, 3'd5, 4'd3);
    expand_until_done(4);
    drain();

    // Random phases on small automata with random configuration.
    items = 0;
    while (items < 190) begin
      idling = ($urandom_range(0, 3) != 0);
      ns = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(2, 8);
      set_all(5'(ns), 4'($urandom_range(0, 15)),
              4'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3)));
      send_any(OP_CLEAR);
      items++;
      n_edges = $urandom_range(3, 14);
      for (int i = 0; i < n_edges; i++) begin
        if ($urandom_range(0, 7) == 0)
          send_any(2'($urandom));
        else if ($urandom_range(0, 5) == 0)
          send(OP_FINAL, 4'($urandom_range(0, 8)), 3'($urandom), 4'($urandom));
        else
          send(OP_EDGE, 4'($urandom_range(0, 8)), 3'($urandom), 4'($urandom_range(0, 8)));
        items++;
      end
      send_any(OP_FINAL);
      items++;
      while (sb.pending_depth != 0 && items < 400) begin
        send_any(OP_EXPAND);
        items++;
      end
      send_any(OP_EXPAND);
      items++;
      drain();
    end

    // A pattern whose deterministic form has 1024 nodes fills the subset table.
    idling = 1;
    set_all(5'd16, 4'd2, 4'd0);
    send(OP_CLEAR, 4'd0, 3'd0, 4'd0);
    send(OP_EDGE, 4'd0, 3'd0, 4'd0);
    send(OP_EDGE, 4'd0, 3'd0, 4'd1);
    send(OP_EDGE, 4'd0, 3'd1, 4'd0);
    for (int i = 1; i <= 9; i++) begin
      send(OP_EDGE, 4'(i), 3'd0, 4'(i + 1));
      send(OP_EDGE, 4'(i), 3'd1, 4'(i + 1));
    end
    send(OP_FINAL, 4'd10, 3'd0, 4'd0);
    for (int i = 0; i < 400 && sb.overflows == 0; i++)
      send_any(OP_EXPAND);
    send(OP_EXPAND, 4'd0, 3'd0, 4'd0);

    drain();
    if (sb.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end
endmodule

@@ files.f @@
hw/rtl/nsc_pkg.sv
hw/rtl/nsc_if.sv
hw/rtl/nfa_subset_construction.sv
test/testbench.sv
